[src/hhs_pkg.sv]
package hhs_pkg;

  // Grid and number format.
  localparam int GRID_SIDE   = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 10;
  localparam int HEIGHT_BITS = 28;

  localparam int CELL_BITS    = $clog2(GRID_SIDE);
  localparam int ADDR_BITS    = 2 * CELL_BITS;
  localparam int GRID_DEPTH   = GRID_SIDE * GRID_SIDE;
  localparam int POS_BITS     = CELL_BITS + FRAC_BITS;
  localparam int FW           = FRAC_BITS + 1;           // fraction 0..one
  localparam int CW           = SAMPLE_BITS + 2;         // corner after substitution
  localparam int DW           = CW + 1;                  // corner difference
  localparam int PW           = DW + FW + 1;             // row lerp
  localparam int QW           = PW + 1;                  // row difference
  localparam int TW           = QW + FW + 1;             // column lerp
  localparam int RW           = TW - FRAC_BITS;          // after fraction cut
  localparam int CFG_IDX_BITS = 2;

  localparam logic [FW-1:0] FRAC_ONE = FW'(1) << FRAC_BITS;
  localparam logic [CELL_BITS-1:0] FIELD_RESET = CELL_BITS'(GRID_SIDE - 1);
  localparam logic signed [RW-1:0] HEIGHT_MAX = RW'((64'sd1 <<< (HEIGHT_BITS - 1)) - 1);
  localparam logic signed [RW-1:0] HEIGHT_MIN = -HEIGHT_MAX - RW'(1);

  // Command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_FIELD_WIDTH = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_FIELD_DEPTH = CFG_IDX_BITS'(1);

  typedef struct packed {
    logic                          cmd;
    logic [CELL_BITS-1:0]          col;
    logic [CELL_BITS-1:0]          row;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [POS_BITS-1:0]           x_pos;
    logic [POS_BITS-1:0]           z_pos;
  } in_word_t;

  typedef struct packed {
    logic signed [HEIGHT_BITS-1:0] height;
    logic                          in_range;
    logic                          is_query;
  } out_word_t;

  // One item handed from the memory sequencer to the arithmetic pipeline.
  typedef struct packed {
    logic          is_query;
    logic          in_range;
    logic [FW-1:0] xx;
    logic [FW-1:0] zz;
  } token_t;

endpackage

[src/hhs_ram.sv]
module hhs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[src/hhs_interp.sv]
module hhs_interp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   tok_v,
  input  hhs_pkg::token_t                        tok,
  input  logic signed [hhs_pkg::SAMPLE_BITS-1:0] h1,
  input  logic signed [hhs_pkg::SAMPLE_BITS-1:0] h2,
  input  logic signed [hhs_pkg::SAMPLE_BITS-1:0] h3,
  input  logic signed [hhs_pkg::SAMPLE_BITS-1:0] h4,
  output logic                                   out_valid,
  output hhs_pkg::out_word_t                     out_word
);

  // Stage 1: corner substitution along the main diagonal.
  logic                             v1_r;
  hhs_pkg::token_t                  t1_r;
  logic signed [hhs_pkg::CW-1:0]    a_r, b_r, c_r, d_r;
  logic signed [hhs_pkg::CW-1:0]    a_nxt, b_nxt, c_nxt, d_nxt;

  always_comb begin
    a_nxt = hhs_pkg::CW'(h1);
    d_nxt = hhs_pkg::CW'(h4);
    if (tok.xx < tok.zz) begin
      b_nxt = hhs_pkg::CW'(h1) + hhs_pkg::CW'(h4) - hhs_pkg::CW'(h3);
      c_nxt = hhs_pkg::CW'(h3);
    end else begin
      b_nxt = hhs_pkg::CW'(h2);
      c_nxt = hhs_pkg::CW'(h1) + hhs_pkg::CW'(h4) - hhs_pkg::CW'(h2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= tok_v;
    end
    t1_r <= tok;
    a_r  <= a_nxt;
    b_r  <= b_nxt;
    c_r  <= c_nxt;
    d_r  <= d_nxt;
  end

  // Stage 2: the two lerps in x, written as a*one + (b-a)*x.
  logic                          v2_r;
  hhs_pkg::token_t               t2_r;
  logic signed [hhs_pkg::DW-1:0] dtop, dbot;
  logic signed [hhs_pkg::FW:0]   xs;
  logic signed [hhs_pkg::PW-1:0] ptop, pbot;
  logic signed [hhs_pkg::PW-1:0] top_r, bot_r, top_nxt, bot_nxt;

  assign dtop    = hhs_pkg::DW'(b_r) - hhs_pkg::DW'(a_r);
  assign dbot    = hhs_pkg::DW'(d_r) - hhs_pkg::DW'(c_r);
  assign xs      = $signed({1'b0, t1_r.xx});
  assign ptop    = hhs_pkg::PW'(dtop) * hhs_pkg::PW'(xs);
  assign pbot    = hhs_pkg::PW'(dbot) * hhs_pkg::PW'(xs);
  assign top_nxt = (hhs_pkg::PW'(a_r) <<< hhs_pkg::FRAC_BITS) + ptop;
  assign bot_nxt = (hhs_pkg::PW'(c_r) <<< hhs_pkg::FRAC_BITS) + pbot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    t2_r  <= t1_r;
    top_r <= top_nxt;
    bot_r <= bot_nxt;
  end

  // Stage 3: the lerp in z.
  logic                          v3_r;
  hhs_pkg::token_t               t3_r;
  logic signed [hhs_pkg::QW-1:0] dcol;
  logic signed [hhs_pkg::FW:0]   zs;
  logic signed [hhs_pkg::TW-1:0] pcol;
  logic signed [hhs_pkg::TW-1:0] sum_r, sum_nxt;

  assign dcol    = hhs_pkg::QW'(bot_r) - hhs_pkg::QW'(top_r);
  assign zs      = $signed({1'b0, t2_r.zz});
  assign pcol    = hhs_pkg::TW'(dcol) * hhs_pkg::TW'(zs);
  assign sum_nxt = (hhs_pkg::TW'(top_r) <<< hhs_pkg::FRAC_BITS) + pcol;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    t3_r  <= t2_r;
    sum_r <= sum_nxt;
  end

  // Stage 4: drop the extra fraction bits toward zero, then saturate.
  logic signed [hhs_pkg::TW-1:0]          biased;
  logic signed [hhs_pkg::RW-1:0]          cut;
  logic signed [hhs_pkg::RW-1:0]          sat;
  hhs_pkg::out_word_t                     word_nxt;

  always_comb begin
    biased = sum_r;
    if (sum_r[hhs_pkg::TW-1]) begin
      biased = sum_r + hhs_pkg::TW'((64'sd1 <<< hhs_pkg::FRAC_BITS) - 1);
    end
    cut = hhs_pkg::RW'(biased >>> hhs_pkg::FRAC_BITS);
    if (cut > hhs_pkg::HEIGHT_MAX) begin
      sat = hhs_pkg::HEIGHT_MAX;
    end else if (cut < hhs_pkg::HEIGHT_MIN) begin
      sat = hhs_pkg::HEIGHT_MIN;
    end else begin
      sat = cut;
    end
    word_nxt.in_range = t3_r.in_range;
    word_nxt.is_query = t3_r.is_query;
    if (t3_r.is_query && t3_r.in_range) begin
      word_nxt.height = sat[hhs_pkg::HEIGHT_BITS-1:0];
    end else begin
      word_nxt.height = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v3_r;
    end
    out_word <= word_nxt;
  end

endmodule

[src/heightfield_height_sampler.sv]
// Height field sampler. A write word stores one signed sample in a 64 x 64 grid held
// in a single-port RAM; a query word returns the height at a 6.10 position,
// interpolated over the two triangles of its grid cell. The grid is not cleared:
// read only samples that have been written. An in-range query reads its four
// corners through the one RAM port and so holds busy through ST_RD1, ST_RD2 and
// ST_RD3, taking no new word meanwhile; writes and out-of-range queries leave
// busy low. Every word produces exactly one result, in order, on a one-cycle
// out_valid strobe that cannot be held off, after passing tok_r and the
// hhs_interp stages; an in-range query first reads its four corners.
// Configuration writes are always accepted (cfg_ready is tied high) and must be
// made only while no word is in flight.
module heightfield_height_sampler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  hhs_pkg::in_word_t                 in_word,
  output logic                              out_valid,
  output hhs_pkg::out_word_t                out_word,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hhs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [hhs_pkg::CELL_BITS-1:0]     cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD1  = 4'b0010,
    ST_RD2  = 4'b0100,
    ST_RD3  = 4'b1000
  } seq_state_t;

  // Configuration registers.
  logic [hhs_pkg::CELL_BITS-1:0] field_width_r, field_depth_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_width_r <= hhs_pkg::FIELD_RESET;
      field_depth_r <= hhs_pkg::FIELD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hhs_pkg::CFG_FIELD_WIDTH: field_width_r <= cfg_wdata;
        hhs_pkg::CFG_FIELD_DEPTH: field_depth_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Split the query position into cell and fraction; the far edge maps to the
  // last cell with a fraction of one.
  logic                          accept, is_query;
  logic                          x_ok, z_ok, q_in;
  logic [hhs_pkg::CELL_BITS-1:0] x_raw, z_raw, x_cell, z_cell;
  logic [hhs_pkg::FW-1:0]        x_frac, z_frac;

  assign accept   = start && !busy;
  assign is_query = (in_word.cmd == hhs_pkg::CMD_QUERY);
  assign x_raw    = in_word.x_pos[hhs_pkg::POS_BITS-1 -: hhs_pkg::CELL_BITS];
  assign z_raw    = in_word.z_pos[hhs_pkg::POS_BITS-1 -: hhs_pkg::CELL_BITS];
  assign x_ok     = (field_width_r != '0) &&
                    (in_word.x_pos <= {field_width_r, hhs_pkg::FRAC_BITS'(0)});
  assign z_ok     = (field_depth_r != '0) &&
                    (in_word.z_pos <= {field_depth_r, hhs_pkg::FRAC_BITS'(0)});
  assign q_in     = x_ok && z_ok;

  always_comb begin
    if (x_raw >= field_width_r) begin
      x_cell = field_width_r - 1'b1;
      x_frac = hhs_pkg::FRAC_ONE;
    end else begin
      x_cell = x_raw;
      x_frac = {1'b0, in_word.x_pos[hhs_pkg::FRAC_BITS-1:0]};
    end
    if (z_raw >= field_depth_r) begin
      z_cell = field_depth_r - 1'b1;
      z_frac = hhs_pkg::FRAC_ONE;
    end else begin
      z_cell = z_raw;
      z_frac = {1'b0, in_word.z_pos[hhs_pkg::FRAC_BITS-1:0]};
    end
  end

  // Corner read sequencer. The first corner is read in the accept cycle, the
  // other three in ST_RD1 to ST_RD3; RAM data comes the cycle after its address.
  seq_state_t                    state_r, state_nxt;
  logic [hhs_pkg::CELL_BITS-1:0] i_r, j_r;
  logic [hhs_pkg::FW-1:0]        xx_r, zz_r;
  logic                          ram_we;
  logic [hhs_pkg::ADDR_BITS-1:0] ram_addr;
  logic [hhs_pkg::SAMPLE_BITS-1:0] ram_rdata;

  assign busy   = (state_r != ST_IDLE);
  assign ram_we = accept && !is_query;

  always_comb begin
    state_nxt = state_r;
    ram_addr  = {in_word.row, in_word.col};
    case (state_r)
      ST_IDLE: begin
        if (is_query) begin
          ram_addr = {z_cell, x_cell};
        end
        if (accept && is_query && q_in) begin
          state_nxt = ST_RD1;
        end
      end
      ST_RD1: begin
        ram_addr  = {j_r, i_r + 1'b1};
        state_nxt = ST_RD2;
      end
      ST_RD2: begin
        ram_addr  = {j_r + 1'b1, i_r};
        state_nxt = ST_RD3;
      end
      ST_RD3: begin
        ram_addr  = {j_r + 1'b1, i_r + 1'b1};
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (accept) begin
      i_r  <= x_cell;
      j_r  <= z_cell;
      xx_r <= x_frac;
      zz_r <= z_frac;
    end
  end

  hhs_ram #(
    .WIDTH (hhs_pkg::SAMPLE_BITS),
    .DEPTH (hhs_pkg::GRID_DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_word.sample),
    .rdata (ram_rdata)
  );

  // Corner capture. The fourth corner is taken straight from the RAM output in
  // the cycle the token is presented to the pipeline.
  logic signed [hhs_pkg::SAMPLE_BITS-1:0] h1_r, h2_r, h3_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_RD1) begin
      h1_r <= ram_rdata;
    end
    if (state_r == ST_RD2) begin
      h2_r <= ram_rdata;
    end
    if (state_r == ST_RD3) begin
      h3_r <= ram_rdata;
    end
  end

  // Writes and out-of-range queries enter the pipeline at once; in-range
  // queries enter after their last corner read, which keeps results in order.
  logic            tok_v_r, tok_v_nxt;
  hhs_pkg::token_t tok_r, tok_nxt;

  always_comb begin
    tok_v_nxt = (accept && (!is_query || !q_in)) || (state_r == ST_RD3);
    if (state_r == ST_RD3) begin
      tok_nxt.is_query = 1'b1;
      tok_nxt.in_range = 1'b1;
      tok_nxt.xx       = xx_r;
      tok_nxt.zz       = zz_r;
    end else begin
      tok_nxt.is_query = is_query;
      tok_nxt.in_range = !is_query;
      tok_nxt.xx       = '0;
      tok_nxt.zz       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_v_r <= 1'b0;
    end else begin
      tok_v_r <= tok_v_nxt;
    end
    tok_r <= tok_nxt;
  end

  hhs_interp u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_v     (tok_v_r),
    .tok       (tok_r),
    .h1        (h1_r),
    .h2        (h2_r),
    .h3        (h3_r),
    .h4        ($signed(ram_rdata)),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

`ifndef SYNTHESIS
  // The grid is never written while a query still has corners to read.
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !ram_we)
    else $error("grid written during a corner read sequence");

  // An in-range query holds busy through ST_RD1, ST_RD2 and ST_RD3, then drops it.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_query && q_in) |=> busy ##1 busy ##1 busy ##1 !busy)
    else $error("corner read sequence has the wrong length");

  // Every token entering the arithmetic pipeline leaves it as an out_valid strobe.
  a_token_result: assert property (@(posedge clk) disable iff (!rst_n)
    tok_v_r |-> ##4 out_valid)
    else $error("result strobe missing for a token");

  // A token follows the last corner read in the next cycle.
  a_rd3_token: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD3) |=> (tok_v_r && tok_r.is_query && tok_r.in_range))
    else $error("query token not issued after last corner read");
`endif

endmodule
